// ----- design/dda_pkg.sv -----
`default_nettype none

package dda_pkg;

  localparam int unsigned MAP_SIZE  = 32;
  localparam int unsigned SCREEN_H  = 480;
  localparam int unsigned SCREEN_W  = 640;
  localparam int unsigned FRAC_BITS = 16;

  localparam int unsigned CELL_W   = 5;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned COL_W    = 10;
  localparam int unsigned ROW_W    = 9;
  localparam int unsigned RGB_W    = 24;
  localparam int unsigned WDIST_W  = 24;
  localparam int unsigned POS_W    = 21;
  localparam int unsigned VEC_W    = 18;
  localparam int unsigned CFG_IDX_W = 3;

  // distances carry a saturation value of 2^62
  localparam int unsigned DIST_W = 63;
  // shared divider: numerator up to 2^(2F), divisor clamped to 2^(2F+1)
  localparam int unsigned DIV_W  = 2 * FRAC_BITS + 1;
  localparam int unsigned DEN_W  = DIV_W + 1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_POS_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_Y = 3'd5;

  typedef struct packed {
    logic                op;
    logic [CELL_W-1:0]   cell_x;
    logic [CELL_W-1:0]   cell_y;
    logic [KIND_W-1:0]   cell_value;
    logic [COL_W-1:0]    column;
  } item_t;

  typedef struct packed {
    logic [COL_W-1:0]    out_column;
    logic [ROW_W-1:0]    wall_top;
    logic [ROW_W-1:0]    wall_bottom;
    logic [RGB_W-1:0]    wall_color;
    logic                hit_side;
    logic [KIND_W-1:0]   wall_kind;
    logic [WDIST_W-1:0]  wall_dist;
    logic                no_wall;
  } result_t;

  function automatic logic [RGB_W-1:0] kind_color(input logic [KIND_W-1:0] kind);
    logic [RGB_W-1:0] c;
    unique case (kind)
      3'd1:    c = 24'hFF0000;
      3'd2:    c = 24'h00FF00;
      3'd3:    c = 24'h0000FF;
      3'd4:    c = 24'hFFFFFF;
      default: c = 24'h800080;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- design/dda_grid_raycast_column_top.sv -----
// Cell write: accepted while idle, busy stays low.
// Column cast of an on-screen column: setup with up to two passes of the shared
// restoring divider plus the shared 18x18 multiplier, at most 66 grid steps and
// a line-height pass of the divider after a hit, then the result strobe, which
// lasts one cycle, cannot be stalled and drops busy.
// Reset clears the control state, then sweeps the 1024-cell map empty with busy high.
`default_nettype none

module dda_grid_raycast_column_top import dda_pkg::*; (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    start,
  output logic                   busy,
  input  wire item_t             item_i,
  output logic                   res_valid_o,
  output result_t                res_o,
  input  wire                    cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire  [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire  [POS_W-1:0]       cfg_data_i
);

  localparam int unsigned ADDR_W   = 2 * CELL_W;
  localparam int unsigned DEPTH    = MAP_SIZE * MAP_SIZE;
  localparam int unsigned WALK_MAX = 2 * MAP_SIZE + 2;
  localparam int unsigned HALF_H   = SCREEN_H / 2;
  localparam logic [DIST_W-1:0] INF = DIST_W'(1) << (DIST_W - 1);
  localparam logic [DIV_W-1:0]  ONE = DIV_W'(1) << FRAC_BITS;
  // camera scale 2^(F+1)/SCREEN_W as a rounded-up reciprocal, exact for all columns
  localparam int unsigned CAM_SH   = 12;
  localparam int unsigned CAM_K_W  = 20;
  localparam logic [CAM_K_W-1:0] CAM_K =
    CAM_K_W'((64'd1 << (FRAC_BITS + 1 + CAM_SH)) / SCREEN_W + 1);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DIV, S_MPX, S_MPY, S_RY, S_DXL, S_DYL,
    S_SX1, S_SX2, S_SY1, S_SY2, S_SYF, S_WSTEP, S_WADDR, S_WCHK, S_LH, S_OUT
  } state_e;

  typedef enum logic [1:0] {DOP_DX, DOP_DY, DOP_LH} dop_e;

  state_e state_q;
  dop_e   dop_q;

  logic [POS_W-1:0]        pos_x_q, pos_y_q;
  logic signed [VEC_W-1:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;

  logic [COL_W-1:0]        col_q;
  logic signed [VEC_W-1:0] cam_q;
  logic signed [20:0]      rx_q, ry_q;
  logic [DIST_W-1:0]       dx_q, dy_q, sx_q, sy_q, perp_q;
  logic signed [35:0]      prod_q;
  logic [35:0]             acc_q;
  logic signed [6:0]       mx_q, my_q;
  logic                    side_q;
  logic [6:0]              step_q;
  logic [KIND_W-1:0]       kind_q;
  logic [DIV_W-1:0]        lh_q;
  logic [ADDR_W-1:0]       clr_q;

  logic [DIV_W-1:0]        div_num_q;
  logic [DEN_W-1:0]        div_den_q;
  logic [DEN_W-1:0]        div_rem_q;
  logic [5:0]              div_cnt_q;

  logic                    res_valid_q;
  result_t                 res_q;

  // map memory
  logic [KIND_W-1:0] mem [DEPTH];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa, mem_ra;
  logic [KIND_W-1:0] mem_wd, mem_rd_q;

  logic accept;
  assign accept = start && !busy;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_q;
    mem_wd = '0;
    if (state_q == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (accept && item_i.op == OP_WRITE) begin
      mem_we = 1'b1;
      mem_wa = {item_i.cell_x, item_i.cell_y};
      mem_wd = item_i.cell_value;
    end
  end

  assign mem_ra = {mx_q[CELL_W-1:0], my_q[CELL_W-1:0]};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_rd_q <= mem[mem_ra];
  end

  // camera coordinate numerator scaled by the reciprocal of the screen width
  logic [COL_W+CAM_K_W-1:0] cam_prod;
  assign cam_prod = item_i.column * CAM_K;

  // shared restoring divider step
  logic [DEN_W:0]   rem_sh;
  logic             q_bit;
  logic [DEN_W-1:0] rem_nx;
  always_comb begin
    rem_sh = {div_rem_q, div_num_q[DIV_W-1]};
    q_bit  = rem_sh >= {1'b0, div_den_q};
    rem_nx = q_bit ? DEN_W'(rem_sh - {1'b0, div_den_q}) : DEN_W'(rem_sh);
  end
  logic [DIV_W-1:0] quo;
  assign quo = {div_num_q[DIV_W-2:0], q_bit};

  // offsets to the next grid line
  logic [FRAC_BITS:0] fx, fy;
  assign fx = rx_q[20] ? {1'b0, pos_x_q[FRAC_BITS-1:0]}
                       : (FRAC_BITS+1)'(ONE) - {1'b0, pos_x_q[FRAC_BITS-1:0]};
  assign fy = ry_q[20] ? {1'b0, pos_y_q[FRAC_BITS-1:0]}
                       : (FRAC_BITS+1)'(ONE) - {1'b0, pos_y_q[FRAC_BITS-1:0]};

  // shared multiplier operands
  logic signed [VEC_W-1:0] mul_a, mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_MPX: begin mul_a = plane_x_q; mul_b = cam_q; end
      S_MPY: begin mul_a = plane_y_q; mul_b = cam_q; end
      S_SX1: begin
        mul_a = $signed({1'b0, dx_q[2*FRAC_BITS:FRAC_BITS]});
        mul_b = $signed({1'b0, fx});
      end
      S_SX2: begin
        mul_a = $signed({2'b0, dx_q[FRAC_BITS-1:0]});
        mul_b = $signed({1'b0, fx});
      end
      S_SY1: begin
        mul_a = $signed({1'b0, dy_q[2*FRAC_BITS:FRAC_BITS]});
        mul_b = $signed({1'b0, fy});
      end
      S_SY2: begin
        mul_a = $signed({2'b0, dy_q[FRAC_BITS-1:0]});
        mul_b = $signed({1'b0, fy});
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  logic [DIST_W-1:0] side_fin_x, side_fin_y;
  assign side_fin_x = dx_q[DIST_W-1] ? ((fx != '0) ? INF : '0)
                      : DIST_W'(acc_q) + DIST_W'(prod_q[35:FRAC_BITS]);
  assign side_fin_y = dy_q[DIST_W-1] ? ((fy != '0) ? INF : '0)
                      : DIST_W'(acc_q) + DIST_W'(prod_q[35:FRAC_BITS]);

  logic [DIST_W:0] sum_x, sum_y;
  assign sum_x = {1'b0, sx_q} + {1'b0, dx_q};
  assign sum_y = {1'b0, sy_q} + {1'b0, dy_q};

  logic [20:0] rx_abs, ry_abs;
  assign rx_abs = rx_q[20] ? 21'(-rx_q) : 21'(rx_q);
  assign ry_abs = ry_q[20] ? 21'(-ry_q) : 21'(ry_q);

  logic [DIST_W-1:0] perp_x, perp_y;
  assign perp_x = (sx_q >= dx_q) ? sx_q - dx_q : '0;
  assign perp_y = (sy_q >= dy_q) ? sy_q - dy_q : '0;

  logic out_grid;
  assign out_grid = mx_q < 0 || my_q < 0 || mx_q >= 7'(MAP_SIZE) || my_q >= 7'(MAP_SIZE);

  logic [DIV_W-2:0] half;
  assign half = lh_q[DIV_W-1:1];

  result_t miss_res;
  always_comb begin
    miss_res            = '0;
    miss_res.out_column = col_q;
    miss_res.no_wall    = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      dop_q       <= DOP_DX;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
      pos_x_q     <= 21'd98304;
      pos_y_q     <= 21'd98304;
      dir_x_q     <= -18'sd65536;
      dir_y_q     <= '0;
      plane_x_q   <= '0;
      plane_y_q   <= 18'sd43254;
      col_q       <= '0;
      cam_q       <= '0;
      rx_q        <= '0;
      ry_q        <= '0;
      dx_q        <= '0;
      dy_q        <= '0;
      sx_q        <= '0;
      sy_q        <= '0;
      perp_q      <= '0;
      prod_q      <= '0;
      acc_q       <= '0;
      mx_q        <= '0;
      my_q        <= '0;
      side_q      <= 1'b0;
      step_q      <= '0;
      kind_q      <= '0;
      lh_q        <= '0;
      div_num_q   <= '0;
      div_den_q   <= '0;
      div_rem_q   <= '0;
      div_cnt_q   <= '0;
    end else begin
      res_valid_q <= 1'b0;
      prod_q      <= mul_a * mul_b;

      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_POS_X:   pos_x_q   <= cfg_data_i;
          REG_POS_Y:   pos_y_q   <= cfg_data_i;
          REG_DIR_X:   dir_x_q   <= $signed(cfg_data_i[VEC_W-1:0]);
          REG_DIR_Y:   dir_y_q   <= $signed(cfg_data_i[VEC_W-1:0]);
          REG_PLANE_X: plane_x_q <= $signed(cfg_data_i[VEC_W-1:0]);
          REG_PLANE_Y: plane_y_q <= $signed(cfg_data_i[VEC_W-1:0]);
          default: ;
        endcase
      end

      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == ADDR_W'(DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start && item_i.op == OP_CAST && item_i.column < COL_W'(SCREEN_W)) begin
            col_q   <= item_i.column;
            cam_q   <= $signed(cam_prod[CAM_SH+VEC_W-1:CAM_SH] - VEC_W'(ONE));
            state_q <= S_MPX;
          end
        end
        S_DIV: begin
          div_num_q <= quo;
          div_rem_q <= rem_nx;
          div_cnt_q <= div_cnt_q + 1'b1;
          if (div_cnt_q == 6'(DIV_W - 1)) begin
            unique case (dop_q)
              DOP_DX:  begin dx_q <= DIST_W'(quo); state_q <= S_DYL; end
              DOP_DY:  begin dy_q <= DIST_W'(quo); state_q <= S_SX1; end
              DOP_LH:  begin lh_q <= quo;          state_q <= S_OUT; end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_MPX: state_q <= S_MPY;
        S_MPY: begin
          rx_q    <= 21'(dir_x_q) + 21'($signed(prod_q[35:FRAC_BITS]));
          state_q <= S_RY;
        end
        S_RY: begin
          ry_q    <= 21'(dir_y_q) + 21'($signed(prod_q[35:FRAC_BITS]));
          state_q <= S_DXL;
        end
        S_DXL: begin
          if (rx_q == '0) begin
            dx_q    <= INF;
            state_q <= S_DYL;
          end else begin
            div_num_q <= ONE << FRAC_BITS;
            div_den_q <= DEN_W'(rx_abs);
            div_rem_q <= '0;
            div_cnt_q <= '0;
            dop_q     <= DOP_DX;
            state_q   <= S_DIV;
          end
        end
        S_DYL: begin
          if (ry_q == '0) begin
            dy_q    <= INF;
            state_q <= S_SX1;
          end else begin
            div_num_q <= ONE << FRAC_BITS;
            div_den_q <= DEN_W'(ry_abs);
            div_rem_q <= '0;
            div_cnt_q <= '0;
            dop_q     <= DOP_DY;
            state_q   <= S_DIV;
          end
        end
        S_SX1: begin
          mx_q    <= 7'(pos_x_q[POS_W-1:FRAC_BITS]);
          my_q    <= 7'(pos_y_q[POS_W-1:FRAC_BITS]);
          step_q  <= '0;
          side_q  <= 1'b0;
          state_q <= S_SX2;
        end
        S_SX2: begin
          acc_q   <= prod_q;
          state_q <= S_SY1;
        end
        S_SY1: begin
          sx_q    <= side_fin_x;
          state_q <= S_SY2;
        end
        S_SY2: begin
          acc_q   <= prod_q;
          state_q <= S_SYF;
        end
        S_SYF: begin
          sy_q    <= side_fin_y;
          state_q <= S_WSTEP;
        end
        S_WSTEP: begin
          if (step_q == 7'(WALK_MAX)) begin
            res_q       <= miss_res;
            res_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end else begin
            step_q <= step_q + 1'b1;
            if (sx_q < sy_q) begin
              sx_q   <= sum_x > {1'b0, INF} ? INF : sum_x[DIST_W-1:0];
              mx_q   <= rx_q[20] ? mx_q - 7'sd1 : mx_q + 7'sd1;
              side_q <= 1'b0;
            end else begin
              sy_q   <= sum_y > {1'b0, INF} ? INF : sum_y[DIST_W-1:0];
              my_q   <= ry_q[20] ? my_q - 7'sd1 : my_q + 7'sd1;
              side_q <= 1'b1;
            end
            state_q <= S_WADDR;
          end
        end
        S_WADDR: begin
          if (out_grid) begin
            res_q       <= miss_res;
            res_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end else begin
            state_q <= S_WCHK;
          end
        end
        S_WCHK: begin
          if (mem_rd_q != '0) begin
            kind_q  <= mem_rd_q;
            perp_q  <= side_q ? perp_y : perp_x;
            state_q <= S_LH;
          end else begin
            state_q <= S_WSTEP;
          end
        end
        S_LH: begin
          if (perp_q == '0) begin
            lh_q    <= '1;
            state_q <= S_OUT;
          end else begin
            div_num_q <= DIV_W'(SCREEN_H) << FRAC_BITS;
            // a divisor beyond the numerator only needs to stay beyond it
            div_den_q <= (perp_q[DIST_W-1:DIV_W] != '0) ? (DEN_W'(1) << DIV_W)
                                                        : DEN_W'(perp_q[DIV_W-1:0]);
            div_rem_q <= '0;
            div_cnt_q <= '0;
            dop_q     <= DOP_LH;
            state_q   <= S_DIV;
          end
        end
        S_OUT: begin
          res_q.out_column  <= col_q;
          res_q.wall_top    <= (half >= (DIV_W-1)'(HALF_H)) ? '0
                               : ROW_W'((DIV_W-1)'(HALF_H) - half);
          res_q.wall_bottom <= (half >= (DIV_W-1)'(HALF_H)) ? ROW_W'(SCREEN_H - 1)
                               : ROW_W'(half + (DIV_W-1)'(HALF_H));
          res_q.wall_color  <= side_q ? (kind_color(kind_q) >> 1) : kind_color(kind_q);
          res_q.hit_side    <= side_q;
          res_q.wall_kind   <= kind_q;
          res_q.wall_dist   <= (perp_q > DIST_W'({WDIST_W{1'b1}})) ? '1
                               : perp_q[WDIST_W-1:0];
          res_q.no_wall     <= 1'b0;
          res_valid_q       <= 1'b1;
          state_q           <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign cfg_ready_o = 1'b1;

endmodule

`default_nettype wire

// ----- design/dda_chk.sv -----
`default_nettype none

module dda_chk import dda_pkg::*; (
  input wire                  clk_i,
  input wire                  rst_ni,
  input wire                  start,
  input wire                  busy,
  input wire item_t           item_i,
  input wire                  res_valid_o,
  input wire result_t         res_o
);

  // a cast of an on-screen column occupies the block
  a_cast_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && item_i.op == OP_CAST && item_i.column < COL_W'(SCREEN_W) |=> busy)
    else $error("cast transfer did not raise busy");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe longer than one cycle");

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy)
    else $error("result shown while busy");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.no_wall |-> res_o.wall_dist == '0 && res_o.wall_kind == '0
      && res_o.wall_top == '0 && res_o.wall_bottom == '0 && res_o.wall_color == '0)
    else $error("miss result carries wall fields");

  a_hit_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.no_wall |-> res_o.wall_kind != '0
      && res_o.wall_top <= res_o.wall_bottom)
    else $error("hit result inconsistent");

endmodule

bind dda_grid_raycast_column_top dda_chk u_dda_chk (.*);

`default_nettype wire

// ----- bench/tb.sv -----
`default_nettype none

module tb;
  import dda_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned DIST_SAT = 64'd1 << 62;
  localparam longint unsigned LINE_SAT = 64'd1 << 40;
  localparam int SETTLE_CYCLES = 500;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [POS_W-1:0]     data;
    item_t                item;
  } action_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                 start = 1'b0;
  logic                 busy;
  item_t                drv_item = '0;
  logic                 res_valid_o;
  result_t              res_o;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [POS_W-1:0]     cfg_data = '0;

  action_t actions[$];
  result_t exp_columns[$];
  int      errors = 0;
  int      quiet = 0;
  int      sent = 0;

  // predictor state
  logic [KIND_W-1:0] grid_map [0:MAP_SIZE*MAP_SIZE-1];
  logic [POS_W-1:0]  m_pos_x, m_pos_y;
  logic [VEC_W-1:0]  m_dir_x, m_dir_y, m_plane_x, m_plane_y;

  dda_grid_raycast_column_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (drv_item),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic report(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic longint unsigned inv_dist(input longint r);
    longint unsigned a;
    if (r == 0) return DIST_SAT;
    a = (r < 0) ? longint'(-r) : longint'(r);
    return (64'd1 << (2 * FRAC_BITS)) / a;
  endfunction

  function automatic longint unsigned cross_dist(input longint unsigned frac,
                                                 input longint unsigned delta);
    if (delta >= DIST_SAT) return (frac != 0) ? DIST_SAT : 0;
    return (delta >> FRAC_BITS) * frac + (((delta & 64'hFFFF) * frac) >> FRAC_BITS);
  endfunction

  function automatic longint unsigned add_sat(input longint unsigned a,
                                              input longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s > DIST_SAT) ? DIST_SAT : s;
  endfunction

  function automatic result_t cast_column(input logic [COL_W-1:0] col);
    result_t r;
    longint unsigned colu, dx, dy, sx, sy, perp, lh;
    logic [RGB_W-1:0] color;
    longint cam, rx, ry, mx, my, stx, sty, ds, de;
    bit side, hit;
    logic [KIND_W-1:0] kind;
    side = 1'b0;
    hit = 1'b0;
    kind = '0;
    colu = 64'(col);
    cam = longint'(((2 * colu) << FRAC_BITS) / SCREEN_W) - 65536;
    rx = longint'($signed(m_dir_x)) + ((longint'($signed(m_plane_x)) * cam) >>> FRAC_BITS);
    ry = longint'($signed(m_dir_y)) + ((longint'($signed(m_plane_y)) * cam) >>> FRAC_BITS);
    dx = inv_dist(rx);
    dy = inv_dist(ry);
    mx = longint'(m_pos_x >> FRAC_BITS);
    my = longint'(m_pos_y >> FRAC_BITS);
    if (rx < 0) begin
      stx = -1; sx = cross_dist(64'(m_pos_x[15:0]), dx);
    end else begin
      stx = 1;  sx = cross_dist(64'd65536 - 64'(m_pos_x[15:0]), dx);
    end
    if (ry < 0) begin
      sty = -1; sy = cross_dist(64'(m_pos_y[15:0]), dy);
    end else begin
      sty = 1;  sy = cross_dist(64'd65536 - 64'(m_pos_y[15:0]), dy);
    end
    if (mx < MAP_SIZE && my < MAP_SIZE) begin
      for (int i = 0; i < 2 * MAP_SIZE + 2; i++) begin
        if (sx < sy) begin
          sx = add_sat(sx, dx); mx += stx; side = 1'b0;
        end else begin
          sy = add_sat(sy, dy); my += sty; side = 1'b1;
        end
        if (mx < 0 || my < 0 || mx >= MAP_SIZE || my >= MAP_SIZE) break;
        kind = grid_map[mx * MAP_SIZE + my];
        if (kind != 0) begin
          hit = 1'b1;
          break;
        end
      end
    end
    r = '0;
    r.out_column = col;
    if (!hit) begin
      r.no_wall = 1'b1;
      return r;
    end
    if (!side) perp = (sx >= dx) ? sx - dx : 0;
    else perp = (sy >= dy) ? sy - dy : 0;
    if (perp == 0) lh = LINE_SAT;
    else begin
      lh = (64'(SCREEN_H) << FRAC_BITS) / perp;
      if (lh > LINE_SAT) lh = LINE_SAT;
    end
    ds = longint'(SCREEN_H / 2) - longint'(lh / 2);
    if (ds < 0) ds = 0;
    de = longint'(lh / 2) + longint'(SCREEN_H / 2);
    if (de >= SCREEN_H) de = longint'(SCREEN_H) - 1;
    case (kind)
      3'd1:    color = 24'hFF0000;
      3'd2:    color = 24'h00FF00;
      3'd3:    color = 24'h0000FF;
      3'd4:    color = 24'hFFFFFF;
      default: color = 24'h800080;
    endcase
    if (side) color = color >> 1;
    r.wall_top    = ds[ROW_W-1:0];
    r.wall_bottom = de[ROW_W-1:0];
    r.wall_color  = color;
    r.hit_side    = side;
    r.wall_kind   = kind;
    r.wall_dist   = (perp > 64'hFFFFFF) ? 24'hFFFFFF : perp[WDIST_W-1:0];
    return r;
  endfunction

  task automatic take_item(input item_t it);
    if (it.op == OP_WRITE) begin
      grid_map[it.cell_x * MAP_SIZE + it.cell_y] = it.cell_value;
    end else if (it.column < SCREEN_W) begin
      exp_columns.push_back(cast_column(it.column));
    end
  endtask

  task automatic take_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [POS_W-1:0] d);
    case (idx)
      REG_POS_X:   m_pos_x   = d;
      REG_POS_Y:   m_pos_y   = d;
      REG_DIR_X:   m_dir_x   = d[VEC_W-1:0];
      REG_DIR_Y:   m_dir_y   = d[VEC_W-1:0];
      REG_PLANE_X: m_plane_x = d[VEC_W-1:0];
      REG_PLANE_Y: m_plane_y = d[VEC_W-1:0];
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start     <= 1'b0;
      cfg_valid <= 1'b0;
      quiet     <= 0;
    end else begin
      quiet <= ((start && !busy) || res_valid_o) ? 0 : quiet + 1;
      if (start && !busy) take_item(drv_item);
      if (cfg_valid && cfg_ready) take_cfg(cfg_index, cfg_data);

      if (start && busy) begin
        // hold until transfer
      end else if (cfg_valid && !cfg_ready) begin
        // hold until transfer
      end else if (actions.size() == 0) begin
        start     <= 1'b0;
        cfg_valid <= 1'b0;
      end else if (actions[0].is_cfg) begin
        start <= 1'b0;
        // only write registers once the block has drained
        if (!(start && !busy) && exp_columns.size() == 0 && quiet >= SETTLE_CYCLES
            && !busy) begin
          cfg_valid <= 1'b1;
          cfg_index <= actions[0].idx;
          cfg_data  <= actions[0].data;
          void'(actions.pop_front());
        end else begin
          cfg_valid <= 1'b0;
        end
      end else begin
        cfg_valid <= 1'b0;
        if ($urandom_range(99) < 14 && !(sent >= 150 && sent < 260)) begin
          start <= 1'b0;
        end else begin
          start    <= 1'b1;
          drv_item <= actions[0].item;
          sent     <= sent + 1;
          void'(actions.pop_front());
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (exp_columns.size() == 0) begin
        report($sformatf("result for column %0d with none expected", res_o.out_column));
      end else begin
        result_t e;
        e = exp_columns.pop_front();
        if (res_o.out_column !== e.out_column)
          report($sformatf("out_column %0d exp %0d", res_o.out_column, e.out_column));
        if (res_o.wall_top !== e.wall_top)
          report($sformatf("col %0d wall_top %0d exp %0d", e.out_column,
                           res_o.wall_top, e.wall_top));
        if (res_o.wall_bottom !== e.wall_bottom)
          report($sformatf("col %0d wall_bottom %0d exp %0d", e.out_column,
                           res_o.wall_bottom, e.wall_bottom));
        if (res_o.wall_color !== e.wall_color)
          report($sformatf("col %0d wall_color %h exp %h", e.out_column,
                           res_o.wall_color, e.wall_color));
        if (res_o.hit_side !== e.hit_side)
          report($sformatf("col %0d hit_side %b exp %b", e.out_column,
                           res_o.hit_side, e.hit_side));
        if (res_o.wall_kind !== e.wall_kind)
          report($sformatf("col %0d wall_kind %0d exp %0d", e.out_column,
                           res_o.wall_kind, e.wall_kind));
        if (res_o.wall_dist !== e.wall_dist)
          report($sformatf("col %0d wall_dist %h exp %h", e.out_column,
                           res_o.wall_dist, e.wall_dist));
        if (res_o.no_wall !== e.no_wall)
          report($sformatf("col %0d no_wall %b exp %b", e.out_column,
                           res_o.no_wall, e.no_wall));
      end
    end
  end

  task automatic add_write(input int x, input int y, input int v);
    action_t a;
    a = '{default: '0};
    a.item.op = OP_WRITE;
    a.item.cell_x = CELL_W'(x);
    a.item.cell_y = CELL_W'(y);
    a.item.cell_value = KIND_W'(v);
    a.item.column = COL_W'($urandom_range(1023));
    actions.push_back(a);
  endtask

  task automatic add_cast(input int c);
    action_t a;
    a = '{default: '0};
    a.item.op = OP_CAST;
    a.item.cell_x = CELL_W'($urandom_range(31));
    a.item.cell_y = CELL_W'($urandom_range(31));
    a.item.cell_value = KIND_W'($urandom_range(7));
    a.item.column = COL_W'(c);
    actions.push_back(a);
  endtask

  task automatic add_setting(input int px, input int py, input int dx, input int dy,
                             input int qx, input int qy);
    int vals[6];
    action_t a;
    vals = '{px, py, dx, dy, qx, qy};
    for (int i = 0; i < 6; i++) begin
      a = '{default: '0};
      a.is_cfg = 1'b1;
      a.idx = CFG_IDX_W'(i);
      a.data = POS_W'(vals[i]);
      // vector registers ignore the top bits; toggle them anyway
      if (i >= REG_DIR_X) a.data[POS_W-1:VEC_W] = 3'($urandom_range(7));
      actions.push_back(a);
    end
  endtask

  initial begin
    int line, kind;
    for (int i = 0; i < MAP_SIZE * MAP_SIZE; i++) grid_map[i] = '0;
    m_pos_x = 21'd98304;
    m_pos_y = 21'd98304;
    m_dir_x = 18'h30000;
    m_dir_y = '0;
    m_plane_x = '0;
    m_plane_y = 18'd43254;

    // empty grid, reset registers, on- and off-screen columns
    add_cast(0); add_cast(320); add_cast(639); add_cast(640); add_cast(1023);
    // walls around the viewer cell
    add_write(0, 0, 1); add_write(0, 1, 1); add_write(0, 2, 2); add_write(1, 0, 3);
    add_write(2, 0, 4); add_write(1, 2, 5); add_write(2, 2, 6); add_write(2, 1, 7);
    add_write(31, 31, 7); add_write(31, 0, 0);
    add_cast(0); add_cast(160); add_cast(320); add_cast(480); add_cast(639);
    add_write(0, 1, 0); add_cast(320); add_write(0, 1, 4); add_cast(320);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: add_setting(65536, 65536, 196608, 0, 0, 43254); // zero distance
        1: add_setting(2097151, 2097151, 131071, 131071, 131072, 131072);
        2: add_setting(0, 0, 131072, 131072, 131071, 131071);
        3: add_setting(98304, 1000000, 0, 0, 43254, 0);
        default: add_setting($urandom_range(2097151), $urandom_range(2097151),
                             $urandom_range(262143), $urandom_range(262143),
                             $urandom_range(262143), $urandom_range(262143));
      endcase
      // a straight wall line, then random traffic
      line = $urandom_range(31);
      kind = $urandom_range(1, 7);
      for (int k = 0; k < 32; k++) begin
        if (p[0]) add_write(line, k, kind);
        else add_write(k, line, kind);
      end
      for (int k = 0; k < 15; k++) begin
        if ($urandom_range(99) < 40)
          add_write($urandom_range(31), $urandom_range(31), $urandom_range(7));
        else if ($urandom_range(7) == 0)
          add_cast($urandom_range(1023));
        else
          add_cast($urandom_range(639));
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (actions.size() != 0 || start || cfg_valid) @(posedge clk_i);
    while (exp_columns.size() != 0 || quiet < SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
